@@ src/prlm_pkg.sv @@
`default_nettype none
package prlm_pkg;

    localparam int NUM_PRIO    = 32;
    localparam int NUM_TASKS   = 32;
    localparam int PRIO_W      = 5;
    localparam int TASK_W      = 5;
    localparam int LINK_W      = 6;
    localparam int COUNT_W     = 6;

    localparam logic [LINK_W-1:0] NONE_TASK = LINK_W'(NUM_TASKS);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } prlm_cmd_t;

    typedef enum logic [1:0]
    {
        ST_DONE           = 2'd0,
        ST_NOT_QUEUED     = 2'd1,
        ST_ALREADY_QUEUED = 2'd2
    } prlm_status_t;

    typedef struct packed
    {
        logic              command;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [PRIO_W-1:0] current_priority;
    } prlm_in_t;

    typedef struct packed
    {
        logic [1:0]         status;
        logic [PRIO_W-1:0]  highest_ready_priority;
        logic [TASK_W-1:0]  highest_ready_task;
        logic               any_ready;
        logic [COUNT_W-1:0] level_count;
    } prlm_out_t;

endpackage
`default_nettype wire

@@ src/priority_ready_list_manager.sv @@
// The accepting edge of a request loads the input register; the list update
// and the status register are written as the request leaves the input register,
// and the result register as it leaves the status register.
// Throughput: one transaction per cycle while responses are taken; each list
// update is computed combinationally from the input register, so back-to-back requests flow.
// Reset: asynchronous, active low; all lists empty, no task queued,
// ready bitmap clear, pipeline empty. Task priorities are not reset.
`default_nettype none
module priority_ready_list_manager
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire prlm_pkg::prlm_in_t   req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output prlm_pkg::prlm_out_t       rsp
);
    import prlm_pkg::*;

    // pipeline control
    logic        s1_valid_reg;
    prlm_in_t    s1_reg;
    logic        s2_valid_reg;
    logic [1:0]  s2_status_reg;
    logic [COUNT_W-1:0] s2_count_reg;
    logic        rsp_valid_reg;
    prlm_out_t   rsp_reg;

    logic        s3_load;
    logic        s2_move;
    logic        s2_free;
    logic        s1_fire;

    // list state
    logic [LINK_W-1:0]  head_reg  [NUM_PRIO];
    logic [LINK_W-1:0]  tail_reg  [NUM_PRIO];
    logic [COUNT_W-1:0] count_reg [NUM_PRIO];
    logic [LINK_W-1:0]  next_reg  [NUM_TASKS];
    logic [LINK_W-1:0]  prev_reg  [NUM_TASKS];
    logic [PRIO_W-1:0]  level_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] queued_reg;
    logic [NUM_PRIO-1:0]  bitmap_reg;

    logic [LINK_W-1:0]  head_next  [NUM_PRIO];
    logic [LINK_W-1:0]  tail_next  [NUM_PRIO];
    logic [COUNT_W-1:0] count_next [NUM_PRIO];
    logic [LINK_W-1:0]  next_next  [NUM_TASKS];
    logic [LINK_W-1:0]  prev_next  [NUM_TASKS];
    logic [NUM_TASKS-1:0] queued_next;
    logic [NUM_PRIO-1:0]  bitmap_next;
    logic               level_we;
    logic [1:0]         status_next;
    logic [COUNT_W-1:0] result_count;

    // result stage
    logic [PRIO_W-1:0] top_prio;
    logic [LINK_W-1:0] top_head;
    prlm_out_t         rsp_next;

    assign s3_load   = !rsp_valid_reg || rsp_ready;
    assign s2_move   = s2_valid_reg && s3_load;
    assign s2_free   = !s2_valid_reg || s2_move;
    assign s1_fire   = s1_valid_reg && s2_free;
    assign req_ready = !s1_valid_reg || s1_fire;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (s1_fire)
                s2_valid_reg <= 1'b1;
            else if (s2_move)
                s2_valid_reg <= 1'b0;
            if (s2_move)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            s1_reg <= req;
        if (s1_fire)
        begin
            s2_status_reg <= status_next;
            s2_count_reg  <= result_count;
        end
        if (s2_move)
            rsp_reg <= rsp_next;
    end

    // combinational list update for the transaction in the input register
    always_comb
    begin
        logic [TASK_W-1:0]  t;
        logic               is_insert;
        logic               was_queued;
        logic [PRIO_W-1:0]  lvl;
        logic [LINK_W-1:0]  head_at;
        logic [LINK_W-1:0]  tail_at;
        logic [COUNT_W-1:0] cnt_at;
        logic [LINK_W-1:0]  nx;
        logic [LINK_W-1:0]  pv;
        logic [LINK_W-1:0]  t_link;

        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        next_next   = next_reg;
        prev_next   = prev_reg;
        queued_next = queued_reg;
        bitmap_next = bitmap_reg;
        level_we    = 1'b0;
        status_next = ST_DONE;
        result_count = '0;

        t          = s1_reg.task_id;
        t_link     = {1'b0, t};
        is_insert  = (s1_reg.command == CMD_INSERT);
        was_queued = queued_reg[t];
        lvl        = (is_insert && !was_queued) ? s1_reg.priority_req : level_reg[t];
        head_at    = head_reg[lvl];
        tail_at    = tail_reg[lvl];
        cnt_at     = count_reg[lvl];
        nx         = next_reg[t];
        pv         = prev_reg[t];

        if (is_insert)
        begin
            if (was_queued)
            begin
                status_next  = ST_ALREADY_QUEUED;
                result_count = cnt_at;
            end
            else
            begin
                level_we        = 1'b1;
                queued_next[t]  = 1'b1;
                bitmap_next[lvl] = 1'b1;
                if (cnt_at == '0)
                begin
                    head_next[lvl] = t_link;
                    tail_next[lvl] = t_link;
                    next_next[t]   = NONE_TASK;
                    prev_next[t]   = NONE_TASK;
                end
                else if (s1_reg.priority_req == s1_reg.current_priority)
                begin
                    if (tail_at != NONE_TASK)
                        next_next[tail_at[TASK_W-1:0]] = t_link;
                    next_next[t]   = NONE_TASK;
                    prev_next[t]   = tail_at;
                    tail_next[lvl] = t_link;
                end
                else
                begin
                    if (head_at != NONE_TASK)
                        prev_next[head_at[TASK_W-1:0]] = t_link;
                    prev_next[t]   = NONE_TASK;
                    next_next[t]   = head_at;
                    head_next[lvl] = t_link;
                end
                count_next[lvl] = cnt_at + COUNT_W'(1);
                result_count    = cnt_at + COUNT_W'(1);
            end
        end
        else
        begin
            if (!was_queued)
            begin
                status_next = ST_NOT_QUEUED;
            end
            else
            begin
                if (cnt_at <= COUNT_W'(1))
                begin
                    head_next[lvl]   = NONE_TASK;
                    tail_next[lvl]   = NONE_TASK;
                    count_next[lvl]  = '0;
                    bitmap_next[lvl] = 1'b0;
                    result_count     = '0;
                end
                else
                begin
                    priority if (head_at == t_link)
                    begin
                        if (nx != NONE_TASK)
                            prev_next[nx[TASK_W-1:0]] = NONE_TASK;
                        head_next[lvl] = nx;
                    end
                    else if (tail_at == t_link)
                    begin
                        if (pv != NONE_TASK)
                            next_next[pv[TASK_W-1:0]] = NONE_TASK;
                        tail_next[lvl] = pv;
                    end
                    else
                    begin
                        if (pv != NONE_TASK)
                            next_next[pv[TASK_W-1:0]] = nx;
                        if (nx != NONE_TASK)
                            prev_next[nx[TASK_W-1:0]] = pv;
                    end
                    count_next[lvl] = cnt_at - COUNT_W'(1);
                    result_count    = cnt_at - COUNT_W'(1);
                end
                next_next[t]   = NONE_TASK;
                prev_next[t]   = NONE_TASK;
                queued_next[t] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PRIO; i++)
            begin
                head_reg[i]  <= NONE_TASK;
                tail_reg[i]  <= NONE_TASK;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                next_reg[i] <= NONE_TASK;
                prev_reg[i] <= NONE_TASK;
            end
            queued_reg <= '0;
            bitmap_reg <= '0;
        end
        else if (s1_fire)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            next_reg   <= next_next;
            prev_reg   <= prev_next;
            queued_reg <= queued_next;
            bitmap_reg <= bitmap_next;
        end
    end

    // priority is only read back for queued tasks, so it needs no reset
    always_ff @(posedge clk)
    begin
        if (s1_fire && level_we)
            level_reg[s1_reg.task_id] <= s1_reg.priority_req;
    end

    // result stage: state registers already hold the update of the stage-2 transaction
    always_comb
    begin
        top_prio = '0;
        for (int i = NUM_PRIO - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
                top_prio = PRIO_W'(i);
        end
        top_head = head_reg[top_prio];

        rsp_next.status                 = s2_status_reg;
        rsp_next.any_ready              = |bitmap_reg;
        rsp_next.highest_ready_priority = top_prio;
        rsp_next.highest_ready_task     =
            ((|bitmap_reg) && top_head != NONE_TASK) ? top_head[TASK_W-1:0] : '0;
        rsp_next.level_count            = s2_count_reg;
    end

endmodule
`default_nettype wire

@@ src/prlm_checker.sv @@
`default_nettype none
module prlm_checker
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_ready,
    input  wire prlm_pkg::prlm_in_t   req,
    input  wire logic                 rsp_valid,
    input  wire logic                 rsp_ready,
    input  wire prlm_pkg::prlm_out_t  rsp
);
    import prlm_pkg::*;

    // a waiting request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while waiting");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // with nothing ready, priority and task read zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.any_ready |->
            rsp.highest_ready_priority == '0 && rsp.highest_ready_task == '0)
        else $error("idle response carries nonzero priority or task");

    // a nonempty affected list means some list is ready
    a_count_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.level_count != '0 |-> rsp.any_ready)
        else $error("nonzero level count with no task ready");

    // removal of an unqueued task reports an empty count
    a_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_NOT_QUEUED |-> rsp.level_count == '0)
        else $error("ignored remove reports nonzero count");

endmodule

bind priority_ready_list_manager prlm_checker u_prlm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
